// File: rtl/srrw_pkg.sv
// shared constants and types for the selective-repeat receive window
package srrw_pkg;

    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 11;
    localparam int TOTAL_W     = 15;
    localparam int WINDOW_MAX  = 16;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int WIN_W       = SLOT_W + 1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(WINDOW_MAX);

    // remainder unit: bits of the sequence number per cycle
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = SEQ_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic mod_start;
        logic emit_error;
        logic emit_drop;
        logic emit_end;
        logic do_buffer;
        logic deliver_init;
        logic deliver_step;
    } srrw_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic bad;
        logic in_window;
        logic is_expected;
        logic is_end;
        logic mod_done;
        logic more;
    } srrw_status_t;

endpackage

// File: rtl/srrw_mod.sv
// iterative remainder of the sequence number by the window size
module srrw_mod
    import srrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SEQ_W-1:0]  dividend,
    input  logic [WIN_W-1:0]  divisor,
    output logic              done,
    output logic [SLOT_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEQ_W-1:0]     shift_reg, shift_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;
    logic [SLOT_W-1:0]    rem_step;

    // restoring steps, one bit each, a digit per cycle
    always_comb
    begin
        logic [WIN_W-1:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < MOD_DIGIT_W; i++)
        begin
            r = {r[WIN_W-2:0], shift_reg[SEQ_W-1-i]};
            if (r >= divisor)
            begin
                r = r - divisor;
            end
        end
        rem_step = r[SLOT_W-1:0];
    end

    // sequencing of the digit steps
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << MOD_DIGIT_W;
            rem_next   = rem_step;
            cnt_next   = cnt_reg + MOD_CNT_W'(1);
            if (cnt_reg == MOD_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/srrw_datapath.sv
// window state, slot store, delivery walk and result registers
module srrw_datapath
    import srrw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [WIN_W-1:0]   cfg_wr_data,
    input  logic [SEQ_W-1:0]   seq_number,
    input  logic               is_end,
    input  logic               checksum_good,
    input  logic [LEN_W-1:0]   payload_length,
    input  srrw_cmd_t          cmd,
    output srrw_status_t       status,
    output logic               result_valid,
    output logic               deliver_valid,
    output logic [SEQ_W-1:0]   deliver_seq,
    output logic [SLOT_W-1:0]  deliver_slot,
    output logic [LEN_W-1:0]   deliver_length,
    output logic               ack_valid,
    output logic [SEQ_W-1:0]   ack_seq,
    output logic               end_seen,
    output logic               checksum_error,
    output logic [TOTAL_W-1:0] total_bytes,
    output logic               last
);

    // configuration and window state
    logic [WIN_W-1:0]      window_reg;
    logic [SEQ_W-1:0]      expected_reg, expected_next;
    logic [WINDOW_MAX-1:0] buffered_reg, buffered_next;
    logic [LEN_W-1:0]      slot_length_mem [WINDOW_MAX];
    logic [LEN_W-1:0]      slot_len_rd_reg;

    // captured transaction
    logic [SEQ_W-1:0]      seq_reg;
    logic                  end_reg;
    logic                  good_reg;
    logic [LEN_W-1:0]      len_reg;

    // delivery walk
    logic [SEQ_W-1:0]      cur_seq_reg, cur_seq_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]     step_reg, step_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;

    // result registers
    logic                  res_valid_reg, res_valid_next;
    logic                  dv_reg, dv_next;
    logic [SEQ_W-1:0]      dseq_reg, dseq_next;
    logic [SLOT_W-1:0]     dslot_reg, dslot_next;
    logic [LEN_W-1:0]      dlen_reg, dlen_next;
    logic                  ackv_reg, ackv_next;
    logic [SEQ_W-1:0]      ackseq_reg, ackseq_next;
    logic                  endf_reg, endf_next;
    logic                  cerr_reg, cerr_next;
    logic [TOTAL_W-1:0]    tot_reg, tot_next;
    logic                  last_reg, last_next;

    logic [WIN_W-1:0]      eff_window;
    logic [SEQ_W-1:0]      seq_gap;
    logic                  mod_done;
    logic [SLOT_W-1:0]     mod_rem;
    logic [WIN_W-1:0]      slot_inc;
    logic [SLOT_W-1:0]     next_slot;
    logic                  step_room;
    logic                  more;
    logic [LEN_W-1:0]      item_len;
    logic [TOTAL_W-1:0]    item_total;

    // window clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (window_reg == '0)
        begin
            eff_window = WIN_W'(1);
        end
        else if (window_reg > WIN_W'(WINDOW_MAX))
        begin
            eff_window = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_window = window_reg;
        end
    end

    // slot number of the captured sequence number
    srrw_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (seq_reg),
        .divisor  (eff_window),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // classification of the captured packet
    assign seq_gap = seq_reg - expected_reg;

    // lookahead on the next slot of the walk
    assign slot_inc  = {1'b0, cur_slot_reg} + WIN_W'(1);
    assign next_slot = (slot_inc == eff_window) ? '0 : slot_inc[SLOT_W-1:0];
    assign step_room = ({1'b0, step_reg} + WIN_W'(1)) < eff_window;
    assign more      = step_room && buffered_reg[next_slot];
    assign item_len  = (step_reg == '0) ? len_reg : slot_len_rd_reg;
    assign item_total = total_reg + TOTAL_W'(item_len);

    always_comb
    begin
        status.bad         = !good_reg;
        status.in_window   = (seq_gap != '0) && (seq_gap < SEQ_W'(eff_window));
        status.is_expected = (seq_gap == '0);
        status.is_end      = end_reg;
        status.mod_done    = mod_done;
        status.more        = more;
    end

    // next state of window, walk and result
    always_comb
    begin
        expected_next  = expected_reg;
        buffered_next  = buffered_reg;
        cur_seq_next   = cur_seq_reg;
        cur_slot_next  = cur_slot_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        res_valid_next = 1'b0;
        dv_next        = 1'b0;
        dseq_next      = '0;
        dslot_next     = '0;
        dlen_next      = '0;
        ackv_next      = 1'b0;
        ackseq_next    = '0;
        endf_next      = 1'b0;
        cerr_next      = 1'b0;
        tot_next       = '0;
        last_next      = 1'b0;

        if (cmd.emit_error)
        begin
            res_valid_next = 1'b1;
            cerr_next      = 1'b1;
            last_next      = 1'b1;
        end

        if (cmd.emit_drop)
        begin
            res_valid_next = 1'b1;
            last_next      = 1'b1;
        end

        if (cmd.emit_end)
        begin
            res_valid_next = 1'b1;
            ackv_next      = 1'b1;
            ackseq_next    = seq_reg;
            endf_next      = 1'b1;
            last_next      = 1'b1;
        end

        if (cmd.do_buffer)
        begin
            buffered_next[mod_rem] = 1'b1;
            res_valid_next         = 1'b1;
            ackv_next              = 1'b1;
            ackseq_next            = seq_reg;
            last_next              = 1'b1;
        end

        if (cmd.deliver_init)
        begin
            cur_seq_next  = seq_reg;
            cur_slot_next = mod_rem;
            step_next     = '0;
            total_next    = '0;
        end

        if (cmd.deliver_step)
        begin
            if (step_reg != '0)
            begin
                buffered_next[cur_slot_reg] = 1'b0;
            end
            res_valid_next = 1'b1;
            dv_next        = 1'b1;
            dseq_next      = cur_seq_reg;
            dslot_next     = cur_slot_reg;
            dlen_next      = item_len;
            tot_next       = item_total;
            ackv_next      = !more;
            ackseq_next    = more ? '0 : seq_reg;
            last_next      = !more;
            cur_seq_next   = cur_seq_reg + SEQ_W'(1);
            cur_slot_next  = next_slot;
            step_next      = step_reg + SLOT_W'(1);
            total_next     = item_total;
            if (!more)
            begin
                expected_next = cur_seq_reg + SEQ_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            expected_reg  <= '0;
            buffered_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            expected_reg  <= expected_next;
            buffered_reg  <= buffered_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // slot length store, read ahead at the slot the walk visits next
    always_ff @(posedge clk)
    begin
        if (cmd.do_buffer)
        begin
            slot_length_mem[mod_rem] <= len_reg;
        end
        slot_len_rd_reg <= slot_length_mem[cur_slot_next];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            seq_reg  <= seq_number;
            end_reg  <= is_end;
            good_reg <= checksum_good;
            len_reg  <= payload_length;
        end
        cur_seq_reg  <= cur_seq_next;
        cur_slot_reg <= cur_slot_next;
        step_reg     <= step_next;
        total_reg    <= total_next;
        dv_reg       <= dv_next;
        dseq_reg     <= dseq_next;
        dslot_reg    <= dslot_next;
        dlen_reg     <= dlen_next;
        ackv_reg     <= ackv_next;
        ackseq_reg   <= ackseq_next;
        endf_reg     <= endf_next;
        cerr_reg     <= cerr_next;
        tot_reg      <= tot_next;
        last_reg     <= last_next;
    end

    assign result_valid   = res_valid_reg;
    assign deliver_valid  = dv_reg;
    assign deliver_seq    = dseq_reg;
    assign deliver_slot   = dslot_reg;
    assign deliver_length = dlen_reg;
    assign ack_valid      = ackv_reg;
    assign ack_seq        = ackseq_reg;
    assign end_seen       = endf_reg;
    assign checksum_error = cerr_reg;
    assign total_bytes    = tot_reg;
    assign last           = last_reg;

endmodule

// File: rtl/srrw_ctrl.sv
// controller state machine for the receive window
module srrw_ctrl
    import srrw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  srrw_status_t status,
    output srrw_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CHECK   = 5'b00010,
        ST_MOD     = 5'b00100,
        ST_BUFFER  = 5'b01000,
        ST_DELIVER = 5'b10000
    } srrw_state_t;

    srrw_state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.bad)
                begin
                    cmd.emit_error = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.in_window)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else if (!status.is_expected)
                begin
                    cmd.emit_drop = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.is_end)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    if (status.in_window)
                    begin
                        state_next = ST_BUFFER;
                    end
                    else
                    begin
                        cmd.deliver_init = 1'b1;
                        state_next       = ST_DELIVER;
                    end
                end
            end
            ST_BUFFER:
            begin
                cmd.do_buffer = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DELIVER:
            begin
                cmd.deliver_step = 1'b1;
                if (!status.more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: rtl/selective_repeat_receive_window_unit.sv
// Receive window of a selective-repeat receiver: one packet header per start,
// one or more result transactions strobed by result_valid, one per cycle, which
// the receiver must take as they come. A header is taken when start is high and
// busy is low. A bad checksum, a dropped packet or an expected END packet
// keeps busy high for one cycle. Any packet that needs its slot number waits
// on the remainder unit, which handles four bits of the sequence number a
// cycle, before it is buffered or released, one delivery transaction a cycle.
// Results are registered and appear in the cycle after the state that makes
// them, the last one carrying last and, for a buffered, END or delivered
// packet, the acknowledgement. The user must write the window register through
// cfg_wr_en and cfg_wr_data only while the block is idle; the block itself
// does not enforce this.
module selective_repeat_receive_window_unit
    import srrw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [WIN_W-1:0]   cfg_wr_data,
    input  logic               start,
    output logic               busy,
    input  logic [SEQ_W-1:0]   seq_number,
    input  logic               is_end,
    input  logic               checksum_good,
    input  logic [LEN_W-1:0]   payload_length,
    output logic               result_valid,
    output logic               deliver_valid,
    output logic [SEQ_W-1:0]   deliver_seq,
    output logic [SLOT_W-1:0]  deliver_slot,
    output logic [LEN_W-1:0]   deliver_length,
    output logic               ack_valid,
    output logic [SEQ_W-1:0]   ack_seq,
    output logic               end_seen,
    output logic               checksum_error,
    output logic [TOTAL_W-1:0] total_bytes,
    output logic               last
);

    srrw_cmd_t    cmd;
    srrw_status_t status;

    // sequencing
    srrw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // window state and results
    srrw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .seq_number     (seq_number),
        .is_end         (is_end),
        .checksum_good  (checksum_good),
        .payload_length (payload_length),
        .cmd            (cmd),
        .status         (status),
        .result_valid   (result_valid),
        .deliver_valid  (deliver_valid),
        .deliver_seq    (deliver_seq),
        .deliver_slot   (deliver_slot),
        .deliver_length (deliver_length),
        .ack_valid      (ack_valid),
        .ack_seq        (ack_seq),
        .end_seen       (end_seen),
        .checksum_error (checksum_error),
        .total_bytes    (total_bytes),
        .last           (last)
    );

endmodule

// File: bench/tb_selective_repeat_receive_window_unit.sv
// self-checking testbench for the selective-repeat receive window unit
`timescale 1ns / 100ps

module tb_selective_repeat_receive_window_unit;
    import srrw_pkg::*;

    localparam int PACKET_TARGET = 180;
    localparam int STALL_LIMIT   = 2000;
    localparam int CYCLE_CAP     = 1000000;
    localparam int TAIL_CYCLES   = 40;
    localparam int MAX_SHOWN     = 60;

    // one result transaction as seen on the result ports
    typedef struct packed {
        logic               deliver_valid;
        logic [SEQ_W-1:0]   deliver_seq;
        logic [SLOT_W-1:0]  deliver_slot;
        logic [LEN_W-1:0]   deliver_length;
        logic               ack_valid;
        logic [SEQ_W-1:0]   ack_seq;
        logic               end_seen;
        logic               checksum_error;
        logic [TOTAL_W-1:0] total_bytes;
        logic               last;
    } rx_result_t;

    // window predictor plus the queue of results still owed by the block
    class rx_window_scoreboard;
        logic [WIN_W-1:0] win_reg;
        logic [SEQ_W-1:0] next_seq;
        logic             slot_marked [WINDOW_MAX];
        logic [LEN_W-1:0] slot_len    [WINDOW_MAX];
        rx_result_t       owed_results [$];
        int               errors;

        function new();
            win_reg  = WINDOW_RESET;
            next_seq = '0;
            errors   = 0;
            for (int i = 0; i < WINDOW_MAX; i++)
            begin
                slot_marked[i] = 1'b0;
                slot_len[i]    = '0;
            end
        endfunction

        function void set_window(logic [WIN_W-1:0] value);
            win_reg = value;
        endfunction

        // window size as the block applies it
        function logic [SEQ_W-1:0] eff_win();
            if (win_reg == 0)
                return 1;
            if (win_reg > WINDOW_MAX)
                return WINDOW_MAX;
            return SEQ_W'(win_reg);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // predict the results of one accepted packet; returns 1 if it is dropped
        function automatic bit note_packet(logic [SEQ_W-1:0] seq, logic end_flag, logic good,
                                           logic [LEN_W-1:0] len);
            logic [SEQ_W-1:0]   w;
            logic [SEQ_W-1:0]   seq_gap;
            logic [SEQ_W-1:0]   slot;
            logic [SEQ_W-1:0]   s;
            logic [SEQ_W-1:0]   sl;
            logic [SEQ_W-1:0]   j;
            logic [TOTAL_W-1:0] run_total;
            rx_result_t         r;
            w       = eff_win();
            seq_gap = seq - next_seq;
            slot    = seq % w;
            r    = '0;
            r.last = 1'b1;
            // bad checksum: error transaction only
            if (!good)
            begin
                r.checksum_error = 1'b1;
                owed_results.push_back(r);
                return 1'b0;
            end
            // ahead of expected but inside the window: mark and ack
            if (seq_gap != 0 && seq_gap < w)
            begin
                slot_marked[slot] = 1'b1;
                slot_len[slot]    = len;
                r.ack_valid = 1'b1;
                r.ack_seq   = seq;
                owed_results.push_back(r);
                return 1'b0;
            end
            // outside the window: empty transaction
            if (seq_gap != 0)
            begin
                owed_results.push_back(r);
                return 1'b1;
            end
            // expected end packet
            if (end_flag)
            begin
                r.ack_valid = 1'b1;
                r.ack_seq   = seq;
                r.end_seen  = 1'b1;
                owed_results.push_back(r);
                return 1'b0;
            end
            // in-order delivery followed by the run of marked slots
            run_total        = TOTAL_W'(len);
            r                = '0;
            r.deliver_valid  = 1'b1;
            r.deliver_seq    = seq;
            r.deliver_slot   = slot[SLOT_W-1:0];
            r.deliver_length = len;
            r.total_bytes    = run_total;
            for (j = 1; j < w; j++)
            begin
                s  = seq + j;
                sl = s % w;
                if (!slot_marked[sl])
                    break;
                owed_results.push_back(r);
                run_total        = run_total + TOTAL_W'(slot_len[sl]);
                r                = '0;
                r.deliver_valid  = 1'b1;
                r.deliver_seq    = s;
                r.deliver_slot   = sl[SLOT_W-1:0];
                r.deliver_length = slot_len[sl];
                r.total_bytes    = run_total;
                slot_marked[sl]  = 1'b0;
            end
            next_seq    = seq + j;
            r.ack_valid = 1'b1;
            r.ack_seq   = seq;
            r.last      = 1'b1;
            owed_results.push_back(r);
            return 1'b0;
        endfunction

        task cmp_field(string name, logic [SEQ_W-1:0] got, logic [SEQ_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        // compare one result transaction with the oldest prediction
        task check_result(rx_result_t got);
            rx_result_t want;
            if (owed_results.size() == 0)
            begin
                report("result transaction with nothing predicted");
                return;
            end
            want = owed_results.pop_front();
            cmp_field("deliver_valid",  SEQ_W'(got.deliver_valid),  SEQ_W'(want.deliver_valid));
            cmp_field("deliver_seq",    got.deliver_seq,            want.deliver_seq);
            cmp_field("deliver_slot",   SEQ_W'(got.deliver_slot),   SEQ_W'(want.deliver_slot));
            cmp_field("deliver_length", SEQ_W'(got.deliver_length), SEQ_W'(want.deliver_length));
            cmp_field("ack_valid",      SEQ_W'(got.ack_valid),      SEQ_W'(want.ack_valid));
            cmp_field("ack_seq",        got.ack_seq,                want.ack_seq);
            cmp_field("end_seen",       SEQ_W'(got.end_seen),       SEQ_W'(want.end_seen));
            cmp_field("checksum_error", SEQ_W'(got.checksum_error), SEQ_W'(want.checksum_error));
            cmp_field("total_bytes",    SEQ_W'(got.total_bytes),    SEQ_W'(want.total_bytes));
            cmp_field("last",           SEQ_W'(got.last),           SEQ_W'(want.last));
        endtask

        task flush_check();
            if (owed_results.size() != 0)
                report($sformatf("%0d predicted results never arrived", owed_results.size()));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [WIN_W-1:0]   cfg_wr_data;
    logic               start;
    logic               busy;
    logic [SEQ_W-1:0]   seq_number;
    logic               is_end;
    logic               checksum_good;
    logic [LEN_W-1:0]   payload_length;
    logic               result_valid;
    logic               deliver_valid;
    logic [SEQ_W-1:0]   deliver_seq;
    logic [SLOT_W-1:0]  deliver_slot;
    logic [LEN_W-1:0]   deliver_length;
    logic               ack_valid;
    logic [SEQ_W-1:0]   ack_seq;
    logic               end_seen;
    logic               checksum_error;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;

    rx_window_scoreboard sb = new();
    int packets_sent = 0;
    bit idle_on      = 1'b1;
    int idle_cycles  = 0;
    int run_cycles   = 0;

    selective_repeat_receive_window_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start          (start),
        .busy           (busy),
        .seq_number     (seq_number),
        .is_end         (is_end),
        .checksum_good  (checksum_good),
        .payload_length (payload_length),
        .result_valid   (result_valid),
        .deliver_valid  (deliver_valid),
        .deliver_seq    (deliver_seq),
        .deliver_slot   (deliver_slot),
        .deliver_length (deliver_length),
        .ack_valid      (ack_valid),
        .ack_seq        (ack_seq),
        .end_seen       (end_seen),
        .checksum_error (checksum_error),
        .total_bytes    (total_bytes),
        .last           (last)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result('{deliver_valid, deliver_seq, deliver_slot, deliver_length,
                              ack_valid, ack_seq, end_seen, checksum_error, total_bytes,
                              last});
    end

    // watchdog on stalled handshakes and on overall run length
    always @(posedge clk)
    begin
        run_cycles++;
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT || run_cycles >= CYCLE_CAP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one packet transaction, then a random gap
    task automatic send_packet(logic [SEQ_W-1:0] seq, logic end_flag, logic good,
                               logic [LEN_W-1:0] len);
        int gap;
        @(negedge clk);
        start          = 1'b1;
        seq_number     = seq;
        is_end         = end_flag;
        checksum_good  = good;
        payload_length = len;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (!sb.note_packet(seq, end_flag, good, len))
            packets_sent++;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drop start and wait for every owed result
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.set_window(value);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // a block of consecutive numbers from the expected one, sent out of order
    task automatic send_burst();
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] tmp;
        int               w;
        int               k;
        int               b;
        bit               full_release;
        logic             good;
        logic             end_flag;
        base         = sb.next_seq;
        w            = int'(sb.eff_win());
        full_release = ($urandom_range(0, 2) == 0);
        k            = full_release ? w : $urandom_range(1, w);
        for (int i = 1; i < k; i++)
            order.push_back(base + i);
        for (int i = order.size() - 1; i > 0; i--)
        begin
            b        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[b];
            order[b] = tmp;
        end
        if (full_release)
            order.push_back(base);
        else
            order.insert($urandom_range(0, order.size()), base);
        foreach (order[i])
        begin
            good     = full_release ? 1'b1 : ($urandom_range(0, 11) != 0);
            end_flag = full_release ? 1'b0 : ($urandom_range(0, 15) == 0);
            send_packet(order[i], end_flag, good, pick_len());
            // occasional retransmission of the same sequence number
            if ($urandom_range(0, 9) == 0)
                send_packet(order[i], 1'b0, 1'b1, pick_len());
        end
    endtask

    // stray packets around and far from the window
    task automatic send_noise();
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] seq;
        int               w;
        base = sb.next_seq;
        w    = int'(sb.eff_win());
        case ($urandom_range(0, 3))
            0:       seq = $urandom;
            1:       seq = base + w;
            2:       seq = base - 1;
            default: seq = base + $urandom_range(0, w - 1);
        endcase
        send_packet(seq, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0), pick_len());
    endtask

    // stimulus
    initial
    begin
        int               phase;
        int               phase_end;
        logic [WIN_W-1:0] win_value;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        start          = 1'b0;
        seq_number     = '0;
        is_end         = 1'b0;
        checksum_good  = 1'b0;
        payload_length = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part with the reset window of 16
        send_packet(32'd0, 1'b1, 1'b0, 11'd2047);          // bad checksum
        send_packet(32'hFFFF_FFFF, 1'b0, 1'b1, 11'd2047);  // one behind, dropped
        send_packet(32'd16, 1'b0, 1'b1, 11'd5);            // one past the window
        send_packet(32'd3, 1'b0, 1'b1, 11'd2047);          // buffered
        send_packet(32'd3, 1'b0, 1'b1, 11'd7);             // duplicate rewrites length
        send_packet(32'd1, 1'b1, 1'b1, 11'd9);             // end ahead, kept as data
        send_packet(32'd15, 1'b0, 1'b1, 11'd0);            // window edge
        send_packet(32'd0, 1'b0, 1'b1, 11'd2047);          // releases 0 and 1
        send_packet(32'd2, 1'b0, 1'b1, 11'd1);             // releases 2 and 3
        send_packet(32'd4, 1'b1, 1'b1, 11'd3);             // expected end
        send_packet(32'd3, 1'b0, 1'b1, 11'd3);             // behind, dropped
        send_packet(32'd4, 1'b0, 1'b0, 11'd0);             // bad checksum on expected
        send_packet(32'd4, 1'b0, 1'b1, 11'd0);             // single delivery
        for (int s = 6; s <= 14; s++)
            send_packet(SEQ_W'(s), 1'b0, 1'b1, 11'd2047);
        send_packet(32'd5, 1'b0, 1'b1, 11'd2047);          // long release up to 15

        // random phases, each under its own window setting
        phase = 0;
        while (packets_sent < PACKET_TARGET)
        begin
            settle();
            case (phase)
                0:       win_value = 5'd1;
                1:       win_value = 5'd0;
                2:       win_value = 5'd31;
                3:       win_value = 5'd17;
                4:       win_value = 5'd16;
                default: win_value = WIN_W'($urandom_range(0, 31));
            endcase
            write_window(win_value);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_end = packets_sent + $urandom_range(15, 30);
            while (packets_sent < phase_end)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_noise();
                else
                    send_burst();
            end
            phase++;
        end

        // drain and look for stray transactions
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_check();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/srrw_pkg.sv
rtl/srrw_mod.sv
rtl/srrw_datapath.sv
rtl/srrw_ctrl.sv
rtl/selective_repeat_receive_window_unit.sv
bench/tb_selective_repeat_receive_window_unit.sv
